@@ rtl/sorted_list_insert_unit_defines.svh @@
// assertion macros for the sorted list insert unit
// used by rtl files that carry concurrent checks; expects clk and rst_n in scope
`ifndef SORTED_LIST_INSERT_UNIT_DEFINES_SVH
`define SORTED_LIST_INSERT_UNIT_DEFINES_SVH

`ifndef SYNTH
// condition holds at every edge out of reset
`define SLI_ASSERT_HOLDS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("sli check failed");
// same-cycle implication
`define SLI_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sli check failed");
// next-cycle implication
`define SLI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sli check failed");
`else
`define SLI_ASSERT_HOLDS(lbl, cond)
`define SLI_ASSERT_IMPL(lbl, ante, cons)
`define SLI_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/sli_pkg.sv @@
// shared types and codes of the sorted list insert unit
// no dependencies
`default_nettype none

package sli_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 4;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_INSERT = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_NOT_IN = 2'd1,
    STAT_FULL   = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]                command;
    logic signed [DATA_W-1:0]  value;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  element;
    logic [POS_W-1:0]          position;
    logic                      last;
    logic [1:0]                status;
  } out_word_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic                      push;  // write data at index count
    logic                      pop;   // shift toward head, write data at count-1
    logic signed [DATA_W-1:0]  data;
  } cell_ctl_t;

  // compare results gathered from the cell row
  typedef struct packed {
    logic                      front;    // key below entry 0
    logic                      end_lt;   // last entry below key
    logic                      gap_any;  // some strict gap holds the key
    logic                      head_lt;  // entry 0 below key
    logic                      head_gt;  // key below entry 0
    logic signed [DATA_W-1:0]  head_data;
  } row_flags_t;

endpackage

`default_nettype wire

@@ rtl/sli_cell.sv @@
// one storage cell of the list row: holds one entry and compares it to the key
// depends on sli_pkg
`default_nettype none

module sli_cell import sli_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int IDX      = 0,
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input  wire                       clk,
  input  cell_ctl_t                 ctl,
  input  wire [CNT_W-1:0]           count,
  input  wire signed [DATA_W-1:0]   key,
  input  wire signed [DATA_W-1:0]   right_i,
  input  wire                       lt_left_i,
  output logic signed [DATA_W-1:0]  data_o,
  output logic                      lt_o,
  output logic                      gt_o,
  output logic                      last_lt_o,
  output logic                      gap_o
);

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;
  logic                     is_tail;   // index count-1
  logic                     is_free;   // index count
  logic                     in_list;

  assign is_tail = (CNT_W'(IDX + 1) == count);
  assign is_free = (CNT_W'(IDX) == count);
  assign in_list = (CNT_W'(IDX) < count);

  always_comb begin
    data_nxt = data_r;
    if (ctl.pop) begin
      data_nxt = is_tail ? ctl.data : right_i;
    end else if (ctl.push && is_free) begin
      data_nxt = ctl.data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o    = data_r;
  assign lt_o      = (data_r < key);
  assign gt_o      = (key < data_r);
  assign last_lt_o = is_tail && lt_o;
  // gap between left neighbor and this cell
  assign gap_o     = (IDX != 0) && in_list && lt_left_i && gt_o;

endmodule

`default_nettype wire

@@ rtl/sli_ctrl.sv @@
// command sequencer and output register of the sorted list insert unit
// depends on sli_pkg and sorted_list_insert_unit_defines.svh
`default_nettype none
`include "sorted_list_insert_unit_defines.svh"

module sli_ctrl import sli_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  in_word_t                  in_word,
  output logic                      out_valid,
  input  wire                       out_stall,
  output out_word_t                 out_word,
  input  row_flags_t                flags,
  output cell_ctl_t                 cell_ctl,
  output logic [CNT_W-1:0]          count,
  output logic signed [DATA_W-1:0]  key
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHECK = 3'b010,
    S_EMIT  = 3'b100
  } state_t;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_FRONT = 2'd1,
    MODE_END   = 2'd2,
    MODE_GAP   = 2'd3
  } mode_t;

  state_t                   state_r, state_nxt;
  mode_t                    mode_r, mode_nxt;
  status_t                  status_r, status_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         n_out_r, n_out_nxt;
  logic [CNT_W-1:0]         k_r, k_nxt;
  logic [CNT_W-1:0]         popped_r, popped_nxt;
  logic                     prev_lt_r, prev_lt_nxt;
  logic                     done_r, done_nxt;
  logic signed [DATA_W-1:0] key_r, key_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_word_t                out_word_r, out_word_nxt;
  logic                     out_ready;
  logic                     in_acc;
  logic                     emit_v;
  logic                     last_emit;
  logic                     ins_ok;

  assign out_ready = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == S_IDLE) && out_ready);
  assign in_acc    = in_valid && !in_stall;

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    status_nxt    = status_r;
    count_nxt     = count_r;
    n_out_nxt     = n_out_r;
    k_nxt         = k_r;
    popped_nxt    = popped_r;
    prev_lt_nxt   = prev_lt_r;
    done_nxt      = done_r;
    key_nxt       = key_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    out_word_nxt  = out_word_r;
    cell_ctl      = '0;
    emit_v        = 1'b0;
    last_emit     = 1'b0;
    ins_ok        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (cmd_t'(in_word.command))
            CMD_CLEAR: begin
              count_nxt = '0;
            end
            CMD_APPEND: begin
              out_valid_nxt        = 1'b1;
              out_word_nxt.element = in_word.value;
              out_word_nxt.last    = 1'b1;
              if (count_r < CNT_W'(CAPACITY)) begin
                cell_ctl.push         = 1'b1;
                cell_ctl.data         = in_word.value;
                count_nxt             = count_r + CNT_W'(1);
                out_word_nxt.position = POS_W'(count_r);
                out_word_nxt.status   = STAT_OK;
              end else begin
                out_word_nxt.position = POS_W'(CAPACITY - 1);
                out_word_nxt.status   = STAT_FULL;
              end
            end
            CMD_INSERT: begin
              key_nxt   = in_word.value;
              state_nxt = S_CHECK;
            end
            default: ;
          endcase
        end
      end

      S_CHECK: begin
        k_nxt       = '0;
        popped_nxt  = '0;
        prev_lt_nxt = 1'b0;
        done_nxt    = 1'b0;
        state_nxt   = S_EMIT;
        if (count_r == CNT_W'(CAPACITY)) begin
          status_nxt = STAT_FULL;
          mode_nxt   = MODE_NONE;
        end else if (count_r == '0 || flags.front) begin
          status_nxt = STAT_OK;
          mode_nxt   = MODE_FRONT;
          ins_ok     = 1'b1;
        end else if (flags.end_lt) begin
          status_nxt = STAT_OK;
          mode_nxt   = MODE_END;
          ins_ok     = 1'b1;
        end else if (flags.gap_any) begin
          status_nxt = STAT_OK;
          mode_nxt   = MODE_GAP;
          ins_ok     = 1'b1;
        end else begin
          status_nxt = STAT_NOT_IN;
          mode_nxt   = MODE_NONE;
        end
        n_out_nxt = count_r + CNT_W'(ins_ok);
      end

      S_EMIT: begin
        if (out_ready) begin
          case (mode_r)
            MODE_FRONT: emit_v = !done_r;
            MODE_END:   emit_v = !done_r && (popped_r == count_r);
            MODE_GAP:   emit_v = !done_r && (popped_r != '0) && prev_lt_r && flags.head_gt;
            default:    emit_v = 1'b0;
          endcase
          cell_ctl.data = emit_v ? key_r : flags.head_data;
          if (emit_v) begin
            cell_ctl.push = 1'b1;
            count_nxt     = count_r + CNT_W'(1);
            done_nxt      = 1'b1;
          end else begin
            cell_ctl.pop  = 1'b1;
            popped_nxt    = popped_r + CNT_W'(1);
            prev_lt_nxt   = flags.head_lt;
          end
          last_emit             = ((k_r + CNT_W'(1)) == n_out_r);
          out_valid_nxt         = 1'b1;
          out_word_nxt.element  = cell_ctl.data;
          out_word_nxt.position = POS_W'(k_r);
          out_word_nxt.last     = last_emit;
          out_word_nxt.status   = status_r;
          k_nxt                 = k_r + CNT_W'(1);
          if (last_emit) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      done_r      <= 1'b0;
      mode_r      <= MODE_NONE;
      status_r    <= STAT_OK;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      done_r      <= done_nxt;
      mode_r      <= mode_nxt;
      status_r    <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_out_r    <= n_out_nxt;
    k_r        <= k_nxt;
    popped_r   <= popped_nxt;
    prev_lt_r  <= prev_lt_nxt;
    key_r      <= key_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign count     = count_r;
  assign key       = key_r;

  // list never grows past its capacity
  `SLI_ASSERT_HOLDS(a_count_bound, count_r <= CNT_W'(CAPACITY))
  // row command is either a rotate or a push, never both
  `SLI_ASSERT_HOLDS(a_push_pop_excl, !(cell_ctl.push && cell_ctl.pop))
  // a successful insert has placed the key by the final word
  `SLI_ASSERT_IMPL(a_insert_placed,
    state_r == S_EMIT && out_ready && last_emit && status_r == STAT_OK,
    done_r || emit_v)
  // without a placement the emitted length is the stored length
  `SLI_ASSERT_IMPL(a_plain_length,
    state_r == S_EMIT && mode_r == MODE_NONE, count_r == n_out_r)

endmodule

`default_nettype wire

@@ rtl/sorted_list_insert_unit.sv @@
// sorted list insert unit: bounded list of signed 32-bit words in a row of cells
// timing: an append word appears in the cycle after acceptance; an insert first runs a
//   compare step, then emits count (+1 when placed) words, one per cycle while out_stall is low
// acceptance: in_stall stays high until the last word of an insert is emitted, so no new
//   command is taken during an insert; clear and append are taken when the output is ready
// reset: synchronous active-low rst_n empties the list, entries hold no reset value
`default_nettype none

module sorted_list_insert_unit import sli_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  in_word_t   in_word,
  output logic       out_valid,
  input  wire        out_stall,
  output out_word_t  out_word
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // row broadcast and gathered compare results
  cell_ctl_t                cell_ctl;
  row_flags_t               flags;
  logic [CNT_W-1:0]         count;
  logic signed [DATA_W-1:0] key;

  // per-cell taps
  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]      lt_vec;
  logic [CAPACITY-1:0]      gt_vec;
  logic [CAPACITY-1:0]      last_lt_vec;
  logic [CAPACITY-1:0]      gap_vec;

  sli_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .flags     (flags),
    .cell_ctl  (cell_ctl),
    .count     (count),
    .key       (key)
  );

  // cell 0 is the head of the row; a rotate moves every word one cell
  // toward the head and lands the emitted word at the tail
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] right_data;
    logic                     left_lt;

    if (i == CAPACITY - 1) begin : g_end
      assign right_data = cell_data[i];
    end else begin : g_mid
      assign right_data = cell_data[i + 1];
    end

    if (i == 0) begin : g_head
      assign left_lt = 1'b0;
    end else begin : g_body
      assign left_lt = lt_vec[i - 1];
    end

    sli_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (i)
    ) u_cell (
      .clk       (clk),
      .ctl       (cell_ctl),
      .count     (count),
      .key       (key),
      .right_i   (right_data),
      .lt_left_i (left_lt),
      .data_o    (cell_data[i]),
      .lt_o      (lt_vec[i]),
      .gt_o      (gt_vec[i]),
      .last_lt_o (last_lt_vec[i]),
      .gap_o     (gap_vec[i])
    );
  end

  // or-reduce the per-cell placement flags and take the head flags and data from cell 0
  always_comb begin
    flags.front     = gt_vec[0];
    flags.end_lt    = |last_lt_vec;
    flags.gap_any   = |gap_vec;
    flags.head_lt   = lt_vec[0];
    flags.head_gt   = gt_vec[0];
    flags.head_data = cell_data[0];
  end

endmodule

`default_nettype wire

@@ tb/sv/sorted_list_insert_unit_test.sv @@
// testbench for the sorted list insert unit: directed and random command words
// checked word by word against an in-bench list predictor; depends on sli_pkg
`timescale 1ns / 100ps

module sorted_list_insert_unit_test;
  import sli_pkg::*;

  localparam int CAP       = CAPACITY_DEF;
  localparam int CLK_HALF  = 4;
  localparam int RUN_LIMIT = 200000;
  localparam int TAIL_WAIT = 40;
  localparam int RAND_WORDS = 203;
  localparam int MAX_PRINTS = 100;

  // command code the unit must ignore
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  // receiver stall behavior, switched in phases
  typedef enum logic [1:0] {
    RX_FREE,
    RX_RANDOM,
    RX_BURSTY
  } rx_mode_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  // predicted list contents and the queue of words still owed by the unit
  logic signed [DATA_W-1:0] list_vals [CAP];
  int                       list_len = 0;
  out_word_t                owed_words [$];

  int error_count = 0;
  int cycle_count = 0;
  int burst_left  = 0;

  rx_mode_t rx_mode = RX_FREE;
  int       rx_phase_left = 0;
  int       rx_hold = 0;
  logic     rx_level = 1'b0;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  sorted_list_insert_unit #(
    .CAPACITY (CAP)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
    error_count++;
    if (error_count <= MAX_PRINTS) begin
      $display("%0t mismatch on %s: expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  // appends one expected word to the owed queue
  task automatic queue_owed(input out_word_t r);
    owed_words = {owed_words, r};
  endtask

  // applies one accepted command word to the predicted list and queues the
  // output words it must produce
  task automatic apply_list_command(input in_word_t w);
    logic signed [DATA_W-1:0] v;
    status_t                  st;
    out_word_t                r;
    int                       slot;
    int                       i;
    v    = w.value;
    st   = STAT_OK;
    slot = -1;
    case (w.command)
      CMD_CLEAR: begin
        list_len = 0;
      end
      CMD_APPEND: begin
        r.element = v;
        r.last    = 1'b1;
        if (list_len < CAP) begin
          list_vals[list_len] = v;
          r.position = POS_W'(list_len);
          r.status   = STAT_OK;
          list_len++;
        end else begin
          // full list: nothing stored, position pinned to the top slot
          r.position = POS_W'(CAP - 1);
          r.status   = STAT_FULL;
        end
        queue_owed(r);
      end
      CMD_INSERT: begin
        if (list_len >= CAP) begin
          st = STAT_FULL;
        end else if (list_len == 0 || v < list_vals[0]) begin
          slot = 0;
        end else if (list_vals[list_len-1] < v) begin
          slot = list_len;
        end else begin
          // first strict gap wins; equal neighbors never form a gap
          st = STAT_NOT_IN;
          for (i = 0; i + 1 < list_len; i++) begin
            if (slot < 0 && list_vals[i] < v && v < list_vals[i+1]) begin
              slot = i + 1;
            end
          end
          if (slot >= 0) begin
            st = STAT_OK;
          end
        end
        if (slot >= 0) begin
          for (i = list_len; i > slot; i--) begin
            list_vals[i] = list_vals[i-1];
          end
          list_vals[slot] = v;
          list_len++;
        end
        for (i = 0; i < list_len; i++) begin
          r.element  = list_vals[i];
          r.position = POS_W'(i);
          r.last     = (i == list_len - 1);
          r.status   = st;
          queue_owed(r);
        end
      end
      default: begin
        // unused command: no state change, no output
      end
    endcase
  endtask

  // drives one command word at a rising edge and holds it until accepted;
  // the sender runs in bursts, mostly with idle gaps between them
  task automatic send_word(input logic [1:0] cmd, input logic signed [DATA_W-1:0] v);
    in_word_t w;
    int       gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      // about a quarter of the bursts follow the previous one back to back
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    w.command = cmd;
    w.value   = v;
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    apply_list_command(w);
  endtask

  // receiver: phases of no stall, scattered stalls, and long on/off runs
  always @(posedge clk) begin
    if (rx_phase_left == 0) begin
      rx_mode       = rx_mode_t'($urandom_range(2, 0));
      rx_phase_left = $urandom_range(80, 20);
    end
    rx_phase_left--;
    case (rx_mode)
      RX_FREE: begin
        out_stall <= 1'b0;
      end
      RX_RANDOM: begin
        out_stall <= ($urandom_range(9, 0) < 3);
      end
      default: begin
        if (rx_hold == 0) begin
          rx_level = !rx_level;
          rx_hold  = $urandom_range(8, 1);
        end
        rx_hold--;
        out_stall <= rx_level;
      end
    endcase
  end

  // output checker: every accepted word against the oldest owed word
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (owed_words.size() == 0) begin
        report_mismatch("word with nothing owed", '0, out_word.element);
      end else begin
        want = owed_words.pop_front();
        if (out_word.element !== want.element) begin
          report_mismatch("element", want.element, out_word.element);
        end
        if (out_word.position !== want.position) begin
          report_mismatch("position", DATA_W'(want.position), DATA_W'(out_word.position));
        end
        if (out_word.last !== want.last) begin
          report_mismatch("last", DATA_W'(want.last), DATA_W'(out_word.last));
        end
        if (out_word.status !== want.status) begin
          report_mismatch("status", DATA_W'(want.status), DATA_W'(out_word.status));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // insert into an empty list, after a clear of the already empty list
  task automatic test_empty_insert();
    send_word(CMD_CLEAR, 32'sd0);
    send_word(CMD_INSERT, VAL_MIN);
  endtask

  // back, gap and equal-value placement, extremes included
  task automatic test_insert_placement();
    send_word(CMD_INSERT, VAL_MAX);
    send_word(CMD_INSERT, -32'sd5);
    send_word(CMD_INSERT, VAL_MIN);
    send_word(CMD_INSERT, 32'sd7);
  endtask

  // list built out of order by appends, so placement follows neighbors only
  task automatic test_unordered_list();
    send_word(CMD_CLEAR, 32'sd0);
    send_word(CMD_APPEND, 32'sd5);
    send_word(CMD_APPEND, 32'sd9);
    send_word(CMD_APPEND, 32'sd7);
    send_word(CMD_INSERT, 32'sd5);
    send_word(CMD_INSERT, 32'sd8);
    send_word(CMD_INSERT, 32'sd6);
  endtask

  // fill to capacity, then append and insert into the full list; the unused
  // command in between must leave the list as it was
  task automatic test_full_list();
    int k;
    k = 0;
    while (list_len < CAP) begin
      send_word(CMD_APPEND, k[0] ? (32'shAAAA_AAAA ^ k) : (32'sh5555_5555 ^ k));
      k++;
    end
    send_word(CMD_APPEND, VAL_MAX);
    send_word(CMD_UNUSED, VAL_MIN);
    send_word(CMD_INSERT, 32'sd0);
  endtask

  // random traffic; values cluster near list contents so that equal values,
  // tight gaps and full lists come up often
  task automatic test_random_traffic();
    int                       counted;
    int                       pick;
    int                       tmp;
    logic [1:0]               cmd;
    logic signed [DATA_W-1:0] v;
    counted = 0;
    while (counted < RAND_WORDS) begin
      pick = $urandom_range(99, 0);
      if (pick < 5 || (list_len == CAP && pick < 30)) begin
        cmd = CMD_CLEAR;
      end else if (pick < 9) begin
        cmd = CMD_UNUSED;
      end else if (pick < 55) begin
        cmd = CMD_APPEND;
      end else begin
        cmd = CMD_INSERT;
      end
      case ($urandom_range(3, 0))
        0: v = $urandom;
        1: begin
          tmp = int'($urandom_range(20, 0)) - 10;
          v   = tmp;
        end
        2: begin
          case ($urandom_range(5, 0))
            0: v = VAL_MIN;
            1: v = VAL_MAX;
            2: v = VAL_MIN + 1;
            3: v = VAL_MAX - 1;
            4: v = 32'sd0;
            default: v = -32'sd1;
          endcase
        end
        default: begin
          if (list_len > 0) begin
            tmp = int'($urandom_range(2, 0)) - 1;
            v   = list_vals[$urandom_range(list_len - 1, 0)] + tmp;
          end else begin
            v = $urandom;
          end
        end
      endcase
      send_word(cmd, v);
      if (cmd != CMD_UNUSED) begin
        counted++;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_insert();
    test_insert_placement();
    test_unordered_list();
    test_full_list();
    test_random_traffic();

    in_valid <= 1'b0;
    // drain what the unit still owes, then give it time to show stray words
    while (owed_words.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
